>>> rtl/vml_pkg.sv
// ----------------------------------------------------------------------------
// vml_pkg
// Types and constants shared by the vector magnitude limiter.
// ----------------------------------------------------------------------------
package vml_pkg;

  localparam int unsigned NumLanes  = 3;
  localparam int unsigned CompW     = 32;
  localparam int unsigned MagW      = 31;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;
  // square, sum, root steps, scale multiply, divide steps, output register
  localparam int unsigned Latency   = 2 + SqrtSteps + 1 + DivSteps + 1;

  localparam logic [MagW-1:0] MaxMagReset = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [CompW-1:0] in_x;
    logic signed [CompW-1:0] in_y;
    logic signed [CompW-1:0] in_z;
  } vml_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] out_x;
    logic signed [CompW-1:0] out_y;
    logic signed [CompW-1:0] out_z;
    logic                    was_clamped;
  } vml_out_t;

  // data that rides alongside the root computation
  typedef struct packed {
    logic [NumLanes-1:0][CompW-1:0] orig;
    logic [NumLanes-1:0][CompW-1:0] mag;
    logic [NumLanes-1:0]            neg;
  } vml_side_t;

  // result of one scaling lane
  typedef struct packed {
    logic [CompW-1:0] comp;
    logic             clamped;
  } vml_lane_res_t;

endpackage

>>> rtl/vml_sq_lane.sv
// ----------------------------------------------------------------------------
// vml_sq_lane
// Magnitude, sign and registered square of one vector component.
// ----------------------------------------------------------------------------
module vml_sq_lane import vml_pkg::*; (
  input  logic                   clk_i,
  input  logic [CompW-1:0]       comp_i,
  output logic [CompW-1:0]       mag_o,
  output logic                   neg_o,
  output logic [2*CompW-1:0]     sq_o
);

  logic [CompW-1:0]   mag_d, mag_q;
  logic [2*CompW-1:0] sq_q;
  logic               neg_q;

  // two's complement magnitude, the most negative value stays 2^31
  assign mag_d = comp_i[CompW-1] ? (~comp_i + 1'b1) : comp_i;

  // square register
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= comp_i[CompW-1];
    sq_q  <= {{CompW{1'b0}}, mag_d} * {{CompW{1'b0}}, mag_d};
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;
  assign sq_o  = sq_q;

endmodule

>>> rtl/vml_sqrt.sv
// ----------------------------------------------------------------------------
// vml_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module vml_sqrt import vml_pkg::*; (
  input  logic                 clk_i,
  input  logic [2*CompW-1:0]   rad_i,
  input  vml_side_t            side_i,
  output logic [CompW-1:0]     root_o,
  output vml_side_t            side_o
);

  logic [SqrtSteps-1:0][2*CompW-1:0] rad_q;
  logic [SqrtSteps-1:0][CompW+1:0]   rem_q;
  logic [SqrtSteps-1:0][CompW-1:0]   root_q;
  vml_side_t [SqrtSteps-1:0]         side_q;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    logic [2*CompW-1:0] rad_in;
    logic [CompW+1:0]   rem_in;
    logic [CompW-1:0]   root_in;
    vml_side_t          side_in;
    logic [CompW+3:0]   part;
    logic [CompW+3:0]   trial;
    logic [CompW+3:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign part  = {rem_in, rad_in[2*CompW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = part - trial;
    assign ge    = (part >= trial);

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[2*CompW-3:0], 2'b00};
      rem_q[k]  <= ge ? diff[CompW+1:0] : part[CompW+1:0];
      root_q[k] <= {root_in[CompW-2:0], ge};
      side_q[k] <= side_in;
    end
  end

  assign root_o = root_q[SqrtSteps-1];
  assign side_o = side_q[SqrtSteps-1];

endmodule

>>> rtl/vml_div_lane.sv
// ----------------------------------------------------------------------------
// vml_div_lane
// Scales one component by max / norm: a multiply, then restoring division.
// ----------------------------------------------------------------------------
module vml_div_lane import vml_pkg::*; (
  input  logic                clk_i,
  input  logic [CompW-1:0]    mag_i,
  input  logic                neg_i,
  input  logic [CompW-1:0]    orig_i,
  input  logic [MagW-1:0]     max_i,
  input  logic [CompW-1:0]    norm_i,
  input  logic                clamp_i,
  output vml_lane_res_t       res_o
);

  localparam int unsigned ProdW = CompW + MagW;

  logic [ProdW-1:0] prod_q;
  logic [CompW-1:0] nrm_q, orig_q;
  logic             neg_q, clamp_q;

  // scale multiply
  always_ff @(posedge clk_i) begin
    prod_q  <= {{MagW{1'b0}}, mag_i} * {{CompW{1'b0}}, max_i};
    nrm_q   <= norm_i;
    orig_q  <= orig_i;
    neg_q   <= neg_i;
    clamp_q <= clamp_i;
  end

  logic [DivSteps-1:0][CompW-1:0] rem_q;
  logic [DivSteps-1:0][MagW-1:0]  dvd_q;
  logic [DivSteps-1:0][MagW-1:0]  quo_q;
  logic [DivSteps-1:0][CompW-1:0] dnrm_q, dorig_q;
  logic [DivSteps-1:0]            dneg_q, dclamp_q;

  // quotient stays below 2^31, so the top dividend bits start as remainder
  for (genvar j = 0; j < DivSteps; j++) begin : g_stage
    logic [CompW-1:0] rem_in, nrm_in, orig_in;
    logic [MagW-1:0]  dvd_in, quo_in;
    logic             neg_in, clamp_in;
    logic [CompW:0]   part;
    logic [CompW:0]   diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in   = prod_q[ProdW-1:MagW];
      assign dvd_in   = prod_q[MagW-1:0];
      assign quo_in   = '0;
      assign nrm_in   = nrm_q;
      assign orig_in  = orig_q;
      assign neg_in   = neg_q;
      assign clamp_in = clamp_q;
    end else begin : g_next
      assign rem_in   = rem_q[j-1];
      assign dvd_in   = dvd_q[j-1];
      assign quo_in   = quo_q[j-1];
      assign nrm_in   = dnrm_q[j-1];
      assign orig_in  = dorig_q[j-1];
      assign neg_in   = dneg_q[j-1];
      assign clamp_in = dclamp_q[j-1];
    end

    assign part = {rem_in, dvd_in[MagW-1]};
    assign diff = part - {1'b0, nrm_in};
    assign ge   = (part >= {1'b0, nrm_in});

    always_ff @(posedge clk_i) begin
      rem_q[j]    <= ge ? diff[CompW-1:0] : part[CompW-1:0];
      dvd_q[j]    <= {dvd_in[MagW-2:0], 1'b0};
      quo_q[j]    <= {quo_in[MagW-2:0], ge};
      dnrm_q[j]   <= nrm_in;
      dorig_q[j]  <= orig_in;
      dneg_q[j]   <= neg_in;
      dclamp_q[j] <= clamp_in;
    end
  end

  // restore the sign or pass the component through
  logic [CompW-1:0] q_ext;
  assign q_ext = {1'b0, quo_q[DivSteps-1]};

  always_comb begin
    res_o.clamped = dclamp_q[DivSteps-1];
    if (dclamp_q[DivSteps-1]) begin
      res_o.comp = dneg_q[DivSteps-1] ? (~q_ext + 1'b1) : q_ext;
    end else begin
      res_o.comp = dorig_q[DivSteps-1];
    end
  end

endmodule

>>> rtl/vector_magnitude_limiter.sv
// ----------------------------------------------------------------------------
// vector_magnitude_limiter
// Clamps the length of a signed Q16.16 3D vector to a configured maximum.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         start, busy               in_i  (vml_in_t)
// result    out        done_o (one-cycle strobe) res_o (vml_out_t)
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (max_magnitude)
//
// A word is taken every cycle; busy is always low.
// From accept to done_o a word passes square, sum, 32 root stages,
// scale multiply, 31 divide stages and the output register.
// Reset clears the valid pipeline and loads max_magnitude with 0x7FFFFFFF.
// The receiver cannot stall; done_o marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module vector_magnitude_limiter import vml_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  vml_in_t         in_i,
  output logic            done_o,
  output vml_out_t        res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [MagW-1:0] cfg_data_i
);

  logic [MagW-1:0]    max_q;
  logic [Latency-1:0] vld_q;
  logic               accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxMagReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  // square lanes
  logic [NumLanes-1:0][CompW-1:0]   comp_in, mag, orig_q;
  logic [NumLanes-1:0]              neg;
  logic [NumLanes-1:0][2*CompW-1:0] sq;

  assign comp_in = {in_i.in_z, in_i.in_y, in_i.in_x};

  for (genvar i = 0; i < NumLanes; i++) begin : g_sq
    vml_sq_lane u_sq (
      .clk_i  (clk_i),
      .comp_i (comp_in[i]),
      .mag_o  (mag[i]),
      .neg_o  (neg[i]),
      .sq_o   (sq[i])
    );
  end

  always_ff @(posedge clk_i) begin
    orig_q <= comp_in;
  end

  // sum of squares
  logic [2*CompW-1:0] sum_q;
  vml_side_t          side_q;

  always_ff @(posedge clk_i) begin
    sum_q       <= sq[0] + sq[1] + sq[2];
    side_q.orig <= orig_q;
    side_q.mag  <= mag;
    side_q.neg  <= neg;
  end

  // norm
  logic [CompW-1:0] norm;
  vml_side_t        side_r;

  vml_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .side_i (side_q),
    .root_o (norm),
    .side_o (side_r)
  );

  // clamp decision, a zero norm never exceeds the maximum
  logic clamp;
  assign clamp = (norm > {1'b0, max_q});

  // scaling lanes
  vml_lane_res_t [NumLanes-1:0] lane_res;

  for (genvar i = 0; i < NumLanes; i++) begin : g_div
    vml_div_lane u_div (
      .clk_i   (clk_i),
      .mag_i   (side_r.mag[i]),
      .neg_i   (side_r.neg[i]),
      .orig_i  (side_r.orig[i]),
      .max_i   (max_q),
      .norm_i  (norm),
      .clamp_i (clamp),
      .res_o   (lane_res[i])
    );
  end

  // merge lanes into the result word
  vml_out_t res_d, res_q;

  always_comb begin
    res_d.out_x       = lane_res[0].comp;
    res_d.out_y       = lane_res[1].comp;
    res_d.out_z       = lane_res[2].comp;
    res_d.was_clamped = lane_res[0].clamped;
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[Latency-2]) begin
      res_q <= res_d;
    end
  end

  assign done_o = vld_q[Latency-1];
  assign res_o  = res_q;

endmodule

>>> rtl/vml_checker.sv
// ----------------------------------------------------------------------------
// vml_checker
// Port-level checks on the vector magnitude limiter.
// ----------------------------------------------------------------------------
module vml_checker import vml_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  vml_in_t         in_i,
  input  logic            done_o,
  input  vml_out_t        res_o,
  input  logic            cfg_ready_o
);

  // never holds off input or configuration
  a_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o) else $error("block not ready");

  // every accepted word returns after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) done_o) else $error("result missing");

  // no result without a word accepted earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Latency)) else $error("spurious result");

  // an unclamped word passes through unchanged
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.was_clamped) |->
      (res_o.out_x == $past(in_i.in_x, Latency)) &&
      (res_o.out_y == $past(in_i.in_y, Latency)) &&
      (res_o.out_z == $past(in_i.in_z, Latency)))
    else $error("pass-through mismatch");

endmodule

bind vector_magnitude_limiter vml_checker u_vml_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .in_i        (in_i),
  .done_o      (done_o),
  .res_o       (res_o),
  .cfg_ready_o (cfg_ready_o)
);
